// ----- rtl/core/oetq_pkg.sv -----
// Shared types, constants and pointer helpers for the odd/even two-queue dispatcher.
// No dependencies; imported by oetq_ring and the top level.
package oetq_pkg;

  localparam int unsigned RingDepth = 1024;
  localparam int unsigned PtrW      = $clog2(RingDepth);
  localparam int unsigned DataW     = 32;
  localparam int unsigned CreditW   = 2;

  // Odd words served per round before an even word is due.
  localparam logic [CreditW-1:0] OddCredit = CreditW'(2);

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // Occupancy flags of one ring, as seen by the dispatcher.
  typedef struct packed {
    logic empty;
    logic full;
    logic last;   // exactly one word left
  } ring_stat_t;

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] ptr);
    ring_next = (ptr == PtrW'(RingDepth - 1)) ? '0 : ptr + PtrW'(1);
  endfunction

endpackage

// ----- rtl/core/oetq_ring.sv -----
// One ring FIFO: a synchronous word memory with head and tail pointers.
// Depends on oetq_pkg for widths, the pointer increment and the status struct.
module oetq_ring (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  logic                               pop_i,
  input  logic signed [oetq_pkg::DataW-1:0]  wdata_i,
  output oetq_pkg::ring_stat_t               stat_o,
  output logic signed [oetq_pkg::DataW-1:0]  rdata_o
);
  import oetq_pkg::*;

  logic signed [DataW-1:0] mem [RingDepth];
  logic signed [DataW-1:0] rdata_q;
  logic [PtrW-1:0]         head_q, head_d, tail_q, tail_d;
  logic                    do_push;

  assign head_d  = ring_next(head_q);
  assign tail_d  = ring_next(tail_q);

  assign stat_o.empty = (head_q == tail_q);
  assign stat_o.full  = (tail_d == head_q);
  assign stat_o.last  = (head_d == tail_q);

  assign do_push = push_i && !stat_o.full;
  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      if (do_push) begin
        tail_q <= tail_d;
      end
      if (pop_i) begin
        head_q <= head_d;
      end
    end
  end

  // The slot ahead of the tail is written; the slot ahead of the head is read.
  // The read register changes only on a pop, so it holds while the result waits.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[tail_d] <= wdata_i;
    end
    if (pop_i) begin
      rdata_q <= mem[head_d];
    end
  end

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("ring popped while empty");

  a_no_push_and_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && pop_i))
    else $error("ring pushed and popped in one cycle");

  a_full_push_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && stat_o.full) |=> $stable(tail_q))
    else $error("push into full ring moved the tail");

endmodule

// ----- rtl/core/odd_even_two_queue_weighted_dispatch.sv -----
// Top level of the odd/even two-queue weighted dispatcher: round scheduler and result register.
// Depends on oetq_pkg and instantiates oetq_ring twice.
//
// The block takes one word per cycle while in_stall_o is low. A push sorts its value into the
// odd or the even ring by its low bit; a pop serves up to two odd words and then one even word
// per round. Each word gives exactly one result, in the cycle after it is accepted, read
// straight from the ring memory's registered read port; that memory read is the only register
// on the value path. A new word is taken in the same cycle as the previous result is taken, so
// while out_stall_i is low the throughput is one word per cycle. Each ring holds RingDepth-1 =
// 1023 words and needs no clearing after reset.
module odd_even_two_queue_weighted_dispatch (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               action_i,
  input  logic signed [oetq_pkg::DataW-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic signed [oetq_pkg::DataW-1:0]  out_value_o,
  output logic                               from_odd_o
);
  import oetq_pkg::*;

  ring_stat_t              odd_stat, even_stat;
  logic signed [DataW-1:0] odd_rdata, even_rdata;
  logic                    in_acc;
  logic                    odd_push, even_push, odd_pop, even_pop;
  logic [CreditW-1:0]      credit_q, credit_d;
  status_e                 status_q, status_d;
  logic                    out_valid_q, from_odd_q, from_odd_d, pop_ok_q, pop_ok_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    odd_push   = 1'b0;
    even_push  = 1'b0;
    odd_pop    = 1'b0;
    even_pop   = 1'b0;
    credit_d   = credit_q;
    status_d   = StOk;
    from_odd_d = 1'b0;
    pop_ok_d   = 1'b0;
    if (!action_i) begin
      odd_push  = value_i[0];
      even_push = !value_i[0];
      if (value_i[0] ? odd_stat.full : even_stat.full) begin
        status_d = StFull;
      end
    end else begin
      priority if (credit_q < OddCredit && !odd_stat.empty) begin
        odd_pop    = 1'b1;
        from_odd_d = 1'b1;
        pop_ok_d   = 1'b1;
        credit_d   = odd_stat.last ? OddCredit : credit_q + CreditW'(1);
      end else if (!even_stat.empty) begin
        even_pop = 1'b1;
        pop_ok_d = 1'b1;
        credit_d = '0;
      end else if (!odd_stat.empty) begin
        // Even word due but none there: the round starts over with an odd word.
        odd_pop    = 1'b1;
        from_odd_d = 1'b1;
        pop_ok_d   = 1'b1;
        credit_d   = odd_stat.last ? OddCredit : CreditW'(1);
      end else begin
        status_d = StEmpty;
        credit_d = '0;
      end
    end
  end

  oetq_ring u_odd_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc && odd_push),
    .pop_i   (in_acc && odd_pop),
    .wdata_i (value_i),
    .stat_o  (odd_stat),
    .rdata_o (odd_rdata)
  );

  oetq_ring u_even_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc && even_push),
    .pop_i   (in_acc && even_pop),
    .wdata_i (value_i),
    .stat_o  (even_stat),
    .rdata_o (even_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= StOk;
      from_odd_q  <= 1'b0;
      pop_ok_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        credit_q    <= credit_d;
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        from_odd_q  <= from_odd_d;
        pop_ok_q    <= pop_ok_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign from_odd_o  = from_odd_q;
  assign out_value_o = !pop_ok_q ? '0 : (from_odd_q ? odd_rdata : even_rdata);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted word gave no result");

  a_credit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q != 2'd3)
    else $error("odd credit left its range");

  a_pop_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ok_q |-> (status_q == StOk))
    else $error("served word carries an error status");

  a_empty_no_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == StEmpty) |-> (!from_odd_q && credit_q == '0))
    else $error("empty pop left odd flag or credit set");

endmodule
